// ----- sv/fcull_pkg.sv -----
// shared types and constants of the frustum box cull block
`timescale 1ns / 1ps
`default_nettype none

package fcull_pkg;

   // payload widths of the channels
   localparam int FIELD_BITS     = 32;
   localparam int PLANE_SEL_BITS = 3;
   localparam int VERDICT_BITS   = 2;

   // plane store geometry
   localparam int NUM_PLANES     = 6;
   localparam int NUM_COEFS      = 4;
   localparam int NUM_AXES       = 3;
   localparam int PLANE_IDX_BITS = 3;
   localparam int COEF_A         = 0;
   localparam int COEF_B         = 1;
   localparam int COEF_C         = 2;
   localparam int COEF_D         = 3;

   // index of the last plane in a test sweep
   localparam logic [PLANE_IDX_BITS-1:0] LAST_PLANE = PLANE_IDX_BITS'(NUM_PLANES - 1);

   // d at doubled scale in q32.32: one bit for the doubling, sixteen for the fraction
   localparam int D_SHIFT = 17;

   // command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TEST = 1'b1;

   // classification codes
   typedef enum logic [VERDICT_BITS-1:0] {
      VERDICT_INSIDE    = 2'd0,
      VERDICT_INTERSECT = 2'd1,
      VERDICT_OUTSIDE   = 2'd2
   } verdict_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_RESP
   } state_type;

   // control that enters the plane dot unit with each plane
   typedef struct packed {
      logic valid;
      logic last;
   } dot_ctl_type;

   // per-plane outcome leaving the plane dot unit
   typedef struct packed {
      logic valid;
      logic last;
      logic outside;
      logic straddle;
   } dot_res_type;

endpackage

`default_nettype wire

// ----- sv/fcull_if.sv -----
// request and response channel interfaces of the frustum box cull block
`timescale 1ns / 1ps
`default_nettype none

interface fcull_req_if;
   logic                                      valid;
   logic                                      ready;
   logic                                      cmd;
   logic        [fcull_pkg::PLANE_SEL_BITS-1:0] plane_sel;
   logic signed [fcull_pkg::FIELD_BITS-1:0]     coef_a;
   logic signed [fcull_pkg::FIELD_BITS-1:0]     coef_b;
   logic signed [fcull_pkg::FIELD_BITS-1:0]     coef_c;
   logic signed [fcull_pkg::FIELD_BITS-1:0]     coef_d;
   logic signed [fcull_pkg::FIELD_BITS-1:0]     box_min_x;
   logic signed [fcull_pkg::FIELD_BITS-1:0]     box_min_y;
   logic signed [fcull_pkg::FIELD_BITS-1:0]     box_min_z;
   logic signed [fcull_pkg::FIELD_BITS-1:0]     box_max_x;
   logic signed [fcull_pkg::FIELD_BITS-1:0]     box_max_y;
   logic signed [fcull_pkg::FIELD_BITS-1:0]     box_max_z;

   modport source (
      output valid, cmd, plane_sel, coef_a, coef_b, coef_c, coef_d,
             box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
      input  ready
   );
   modport sink (
      input  valid, cmd, plane_sel, coef_a, coef_b, coef_c, coef_d,
             box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
      output ready
   );
endinterface

interface fcull_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [fcull_pkg::VERDICT_BITS-1:0]    verdict;
   logic                                  was_load;

   modport source (output valid, verdict, was_load, input ready);
   modport sink (input valid, verdict, was_load, output ready);
endinterface

`default_nettype wire

// ----- sv/fcull_plane_regs.sv -----
// register store for the six frustum planes, one write and one read port
`timescale 1ns / 1ps
`default_nettype none

module fcull_plane_regs #(
   parameter int CW = 32
) (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        wr_en,
   input  wire        [fcull_pkg::PLANE_SEL_BITS-1:0] wr_sel,
   input  wire signed [CW-1:0]                        wr_coef [fcull_pkg::NUM_COEFS],
   input  wire        [fcull_pkg::PLANE_IDX_BITS-1:0] rd_sel,
   output logic signed [CW-1:0]                       rd_coef [fcull_pkg::NUM_COEFS]
);

   logic signed [CW-1:0] coef_ff [fcull_pkg::NUM_PLANES][fcull_pkg::NUM_COEFS];
   logic                 wr_hit;

   // selects six and seven name no plane and are dropped
   assign wr_hit = wr_en && (wr_sel < fcull_pkg::PLANE_SEL_BITS'(fcull_pkg::NUM_PLANES));

   // plane write, all planes zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < fcull_pkg::NUM_PLANES; p++) begin
            for (int k = 0; k < fcull_pkg::NUM_COEFS; k++) begin
               coef_ff[p][k] <= '0;
            end
         end
      end else if (wr_hit) begin
         for (int k = 0; k < fcull_pkg::NUM_COEFS; k++) begin
            coef_ff[wr_sel][k] <= wr_coef[k];
         end
      end
   end

   // plane read for the dot unit
   always_comb begin
      for (int k = 0; k < fcull_pkg::NUM_COEFS; k++) begin
         rd_coef[k] = coef_ff[rd_sel][k];
      end
   end

endmodule

`default_nettype wire

// ----- sv/fcull_dot_unit.sv -----
// shared three-stage plane dot unit: products, sums, sign tests
`timescale 1ns / 1ps
`default_nettype none

module fcull_dot_unit #(
   parameter int CW = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  fcull_pkg::dot_ctl_type       in_ctl,
   input  wire signed [CW:0]            sum2 [fcull_pkg::NUM_AXES],
   input  wire        [CW-1:0]          dif [fcull_pkg::NUM_AXES],
   input  wire signed [CW-1:0]          coef [fcull_pkg::NUM_COEFS],
   output fcull_pkg::dot_res_type       out_res
);

   localparam int PW = 2 * CW + 1;   // signed center product
   localparam int NW = 2 * CW;       // unsigned extent product
   localparam int MW = 2 * CW + 3;   // doubled m
   localparam int QW = 2 * CW + 2;   // doubled n
   localparam int SW = 2 * CW + 4;   // m plus or minus n

   fcull_pkg::dot_ctl_type s1_ctl_ff, s2_ctl_ff;
   fcull_pkg::dot_res_type res_ff, res_in;

   logic        [CW-1:0] coef_mag [fcull_pkg::NUM_AXES];
   logic signed [PW-1:0] pm_ff [fcull_pkg::NUM_AXES];
   logic        [NW-1:0] pn_ff [fcull_pkg::NUM_AXES];
   logic signed [MW-1:0] d2_ff;
   logic signed [MW-1:0] m2_ff, m2_in;
   logic        [QW-1:0] n2_ff, n2_in;
   logic signed [SW-1:0] m2_ext, n2_ext, upper, lower;

   // coefficient magnitudes, the most negative value maps to its unsigned magnitude
   always_comb begin
      for (int k = 0; k < fcull_pkg::NUM_AXES; k++) begin
         coef_mag[k] = coef[k][CW-1] ? CW'(-coef[k]) : CW'(coef[k]);
      end
   end

   // stage one: one multiplier per term
   always_ff @(posedge clock) begin
      for (int k = 0; k < fcull_pkg::NUM_AXES; k++) begin
         pm_ff[k] <= PW'(sum2[k]) * PW'(coef[k]);
         pn_ff[k] <= NW'(dif[k]) * NW'(coef_mag[k]);
      end
      d2_ff <= MW'(coef[fcull_pkg::COEF_D]) <<< fcull_pkg::D_SHIFT;
   end

   // stage two: doubled m and n
   always_comb begin
      m2_in = d2_ff;
      n2_in = '0;
      for (int k = 0; k < fcull_pkg::NUM_AXES; k++) begin
         m2_in = m2_in + MW'(pm_ff[k]);
         n2_in = n2_in + QW'(pn_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      m2_ff <= m2_in;
      n2_ff <= n2_in;
   end

   // stage three: far corner and near corner sign tests
   assign m2_ext = SW'(m2_ff);
   assign n2_ext = $signed(SW'(n2_ff));
   assign upper  = m2_ext + n2_ext;
   assign lower  = m2_ext - n2_ext;

   always_comb begin
      res_in.valid    = s2_ctl_ff.valid;
      res_in.last     = s2_ctl_ff.last;
      res_in.outside  = upper[SW-1];
      res_in.straddle = lower[SW-1];
   end

   // control pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         res_ff    <= '0;
      end else begin
         s1_ctl_ff <= in_ctl;
         s2_ctl_ff <= s1_ctl_ff;
         res_ff    <= res_in;
      end
   end

   assign out_res = res_ff;

   // an outside plane always tests as straddling too
   a_outside_implies_straddle: assert property (@(posedge clock) disable iff (reset)
      out_res.valid && out_res.outside |-> out_res.straddle)
      else $error("outside without straddle");

   // a plane passes s1_ctl_ff, s2_ctl_ff and res_ff in turn before it leaves
   a_latency: assert property (@(posedge clock) disable iff (reset)
      in_ctl.valid |=> ##2 out_res.valid)
      else $error("dot unit latency broken");

   // the last marker travels with its plane
   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      in_ctl.valid && in_ctl.last |=> ##2 out_res.last)
      else $error("last marker lost");

endmodule

`default_nettype wire

// ----- sv/frustum_box_cull.sv -----
// top level of the frustum box cull block: sequencer, box prep and response register
`timescale 1ns / 1ps
`default_nettype none

// Classifies an axis-aligned box against six stored frustum planes as inside,
// intersecting or outside, and loads planes one at a time. One item is in
// flight at a time: req_chan.ready is high only when the block is idle. A plane
// load goes straight from the transfer to the registered response. A box test
// first registers the center and extent sums, then feeds the six planes one
// at a time into the shared three-stage dot unit, drains it, and holds the
// registered response until it is taken, so the sweep over the six planes
// through the single dot unit sets how long a test takes. All values
// are signed Q16.16; the sums are exact, with no rounding and no overflow.
// Planes are zero after reset, which makes every box inside.
module frustum_box_cull #(
   parameter int COORD_BITS = 32
) (
   input  wire         clock,
   input  wire         reset,
   fcull_req_if.sink   req_chan,
   fcull_rsp_if.source rsp_chan
);

   localparam int CW = (COORD_BITS < fcull_pkg::FIELD_BITS) ? COORD_BITS
                                                           : fcull_pkg::FIELD_BITS;

   fcull_pkg::state_type   state_ff, state_in;
   fcull_pkg::verdict_type verdict_ff, verdict_in;
   fcull_pkg::dot_ctl_type issue_ctl;
   fcull_pkg::dot_res_type dot_res;

   logic [fcull_pkg::PLANE_IDX_BITS-1:0] plane_cnt_ff, plane_cnt_in;
   logic                                 was_load_ff, was_load_in;
   logic                                 any_out_ff, any_out_in;
   logic                                 any_int_ff, any_int_in;
   logic                                 req_fire, rsp_fire, load_fire, test_fire;
   logic                                 issuing;

   logic signed [CW-1:0] box_lo [fcull_pkg::NUM_AXES];
   logic signed [CW-1:0] box_hi [fcull_pkg::NUM_AXES];
   logic signed [CW:0]   sum2_ff [fcull_pkg::NUM_AXES];
   logic signed [CW:0]   sum2_in [fcull_pkg::NUM_AXES];
   logic        [CW-1:0] dif_ff [fcull_pkg::NUM_AXES];
   logic        [CW-1:0] dif_in [fcull_pkg::NUM_AXES];
   logic signed [CW:0]   up_diff, dn_diff;
   logic signed [CW-1:0] wr_coef [fcull_pkg::NUM_COEFS];
   logic signed [CW-1:0] rd_coef [fcull_pkg::NUM_COEFS];

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rsp_fire  = rsp_chan.valid && rsp_chan.ready;
   assign load_fire = req_fire && (req_chan.cmd == fcull_pkg::CMD_LOAD);
   assign test_fire = req_fire && (req_chan.cmd == fcull_pkg::CMD_TEST);

   // fields sign-extended from their low coordinate bits
   assign box_lo[0] = $signed(req_chan.box_min_x[CW-1:0]);
   assign box_lo[1] = $signed(req_chan.box_min_y[CW-1:0]);
   assign box_lo[2] = $signed(req_chan.box_min_z[CW-1:0]);
   assign box_hi[0] = $signed(req_chan.box_max_x[CW-1:0]);
   assign box_hi[1] = $signed(req_chan.box_max_y[CW-1:0]);
   assign box_hi[2] = $signed(req_chan.box_max_z[CW-1:0]);

   assign wr_coef[fcull_pkg::COEF_A] = $signed(req_chan.coef_a[CW-1:0]);
   assign wr_coef[fcull_pkg::COEF_B] = $signed(req_chan.coef_b[CW-1:0]);
   assign wr_coef[fcull_pkg::COEF_C] = $signed(req_chan.coef_c[CW-1:0]);
   assign wr_coef[fcull_pkg::COEF_D] = $signed(req_chan.coef_d[CW-1:0]);

   // doubled center and full extent per axis, swapped corners give the same extent
   always_comb begin
      up_diff = '0;
      dn_diff = '0;
      for (int k = 0; k < fcull_pkg::NUM_AXES; k++) begin
         up_diff    = (CW+1)'(box_hi[k]) - (CW+1)'(box_lo[k]);
         dn_diff    = (CW+1)'(box_lo[k]) - (CW+1)'(box_hi[k]);
         sum2_in[k] = (CW+1)'(box_lo[k]) + (CW+1)'(box_hi[k]);
         dif_in[k]  = (box_hi[k] >= box_lo[k]) ? up_diff[CW-1:0] : dn_diff[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (test_fire) begin
         for (int k = 0; k < fcull_pkg::NUM_AXES; k++) begin
            sum2_ff[k] <= sum2_in[k];
            dif_ff[k]  <= dif_in[k];
         end
      end
   end

   // plane store
   fcull_plane_regs #(
      .CW (CW)
   ) u_plane_regs (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (load_fire),
      .wr_sel  (req_chan.plane_sel),
      .wr_coef (wr_coef),
      .rd_sel  (plane_cnt_ff),
      .rd_coef (rd_coef)
   );

   // shared dot unit
   assign issue_ctl.valid = issuing;
   assign issue_ctl.last  = issuing && (plane_cnt_ff == fcull_pkg::LAST_PLANE);

   fcull_dot_unit #(
      .CW (CW)
   ) u_dot_unit (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (issue_ctl),
      .sum2    (sum2_ff),
      .dif     (dif_ff),
      .coef    (rd_coef),
      .out_res (dot_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fcull_pkg::ST_IDLE: begin
            if (load_fire) begin
               state_in = fcull_pkg::ST_RESP;
            end else if (test_fire) begin
               state_in = fcull_pkg::ST_ISSUE;
            end
         end
         fcull_pkg::ST_ISSUE: begin
            if (plane_cnt_ff == fcull_pkg::LAST_PLANE) begin
               state_in = fcull_pkg::ST_DRAIN;
            end
         end
         fcull_pkg::ST_DRAIN: begin
            if (dot_res.valid && dot_res.last) begin
               state_in = fcull_pkg::ST_RESP;
            end
         end
         fcull_pkg::ST_RESP: begin
            if (rsp_fire) begin
               state_in = fcull_pkg::ST_IDLE;
            end
         end
         default: state_in = fcull_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      issuing        = 1'b0;
      unique case (state_ff)
         fcull_pkg::ST_IDLE:  req_chan.ready = 1'b1;
         fcull_pkg::ST_ISSUE: issuing        = 1'b1;
         fcull_pkg::ST_DRAIN: ;
         fcull_pkg::ST_RESP:  rsp_chan.valid = 1'b1;
         default: ;
      endcase
   end

   // plane counter and verdict accumulation
   always_comb begin
      plane_cnt_in = plane_cnt_ff;
      any_out_in   = any_out_ff;
      any_int_in   = any_int_ff;
      verdict_in   = verdict_ff;
      was_load_in  = was_load_ff;
      if (issuing) begin
         plane_cnt_in = plane_cnt_ff + fcull_pkg::PLANE_IDX_BITS'(1);
      end
      if (dot_res.valid) begin
         any_out_in = any_out_ff | dot_res.outside;
         any_int_in = any_int_ff | dot_res.straddle;
      end
      if (dot_res.valid && dot_res.last) begin
         if (any_out_in) begin
            verdict_in = fcull_pkg::VERDICT_OUTSIDE;
         end else if (any_int_in) begin
            verdict_in = fcull_pkg::VERDICT_INTERSECT;
         end else begin
            verdict_in = fcull_pkg::VERDICT_INSIDE;
         end
      end
      if (load_fire) begin
         verdict_in  = fcull_pkg::VERDICT_INSIDE;
         was_load_in = 1'b1;
      end
      if (test_fire) begin
         plane_cnt_in = '0;
         any_out_in   = 1'b0;
         any_int_in   = 1'b0;
         was_load_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcull_pkg::ST_IDLE;
         plane_cnt_ff <= '0;
         any_out_ff   <= 1'b0;
         any_int_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         plane_cnt_ff <= plane_cnt_in;
         any_out_ff   <= any_out_in;
         any_int_ff   <= any_int_in;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      verdict_ff  <= verdict_in;
      was_load_ff <= was_load_in;
   end

   assign rsp_chan.verdict  = verdict_ff;
   assign rsp_chan.was_load = was_load_ff;

   // a test transfer starts the plane sweep
   a_test_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      test_fire |=> (state_ff == fcull_pkg::ST_ISSUE) && (plane_cnt_ff == '0))
      else $error("test did not start sweep");

   // dot results only show up while a test is under way
   a_dot_in_test: assert property (@(posedge clock) disable iff (reset)
      dot_res.valid |-> (state_ff == fcull_pkg::ST_ISSUE) || (state_ff == fcull_pkg::ST_DRAIN))
      else $error("stray dot result");

   // a load acknowledgement always reports inside
   a_load_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.was_load |-> rsp_chan.verdict == fcull_pkg::VERDICT_INSIDE)
      else $error("load response with verdict");

   // the sweep never runs past the last plane
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      issuing |-> plane_cnt_ff <= fcull_pkg::LAST_PLANE)
      else $error("plane counter out of range");

endmodule

`default_nettype wire

// ----- bench/frustum_box_cull_tb.sv -----
// self-checking testbench of the frustum box cull block with a verdict scoreboard
`timescale 1ns / 1ps

module frustum_box_cull_tb;

   // one unit in signed q16.16
   localparam int ONE = 1 << 16;
   // cycles with no transfer on either channel before the run is abandoned
   localparam int STALL_LIMIT = 4000;
   // settle time after the last response
   localparam int TAIL_CYCLES = 24;
   localparam int NUM_PHASES = 12;
   localparam int TESTS_PER_PHASE = 44;

   // plane layouts used by the random phases
   typedef enum int {
      LAYOUT_CUBE,
      LAYOUT_TILTED,
      LAYOUT_WILD
   } layout_type;

   typedef struct packed {
      logic                                       cmd;
      logic        [fcull_pkg::PLANE_SEL_BITS-1:0] plane_sel;
      logic signed [fcull_pkg::FIELD_BITS-1:0]     coef_a;
      logic signed [fcull_pkg::FIELD_BITS-1:0]     coef_b;
      logic signed [fcull_pkg::FIELD_BITS-1:0]     coef_c;
      logic signed [fcull_pkg::FIELD_BITS-1:0]     coef_d;
      logic signed [fcull_pkg::FIELD_BITS-1:0]     box_min_x;
      logic signed [fcull_pkg::FIELD_BITS-1:0]     box_min_y;
      logic signed [fcull_pkg::FIELD_BITS-1:0]     box_min_z;
      logic signed [fcull_pkg::FIELD_BITS-1:0]     box_max_x;
      logic signed [fcull_pkg::FIELD_BITS-1:0]     box_max_y;
      logic signed [fcull_pkg::FIELD_BITS-1:0]     box_max_z;
   } cull_item_type;

   typedef struct packed {
      fcull_pkg::verdict_type verdict;
      logic                   was_load;
   } cull_result_type;

   // mirrors the plane store and keeps the verdicts still owed by the block
   class cull_checker;
      logic signed [fcull_pkg::FIELD_BITS-1:0]
                       plane_store [fcull_pkg::NUM_PLANES][fcull_pkg::NUM_COEFS];
      cull_result_type pending_verdicts [$];
      int              error_count;

      function new();
         foreach (plane_store[p, k]) plane_store[p][k] = '0;
         error_count = 0;
      endfunction

      // exact box against six planes at doubled scale
      function fcull_pkg::verdict_type classify_box(cull_item_type it);
         logic signed [127:0]    lo [fcull_pkg::NUM_AXES];
         logic signed [127:0]    hi [fcull_pkg::NUM_AXES];
         logic signed [127:0]    mid2 [fcull_pkg::NUM_AXES];
         logic signed [127:0]    span [fcull_pkg::NUM_AXES];
         logic signed [127:0]    coef;
         logic signed [127:0]    coef_mag;
         logic signed [127:0]    m2;
         logic signed [127:0]    n2;
         logic signed [127:0]    outer;
         logic signed [127:0]    inner;
         fcull_pkg::verdict_type v;
         v = fcull_pkg::VERDICT_INSIDE;
         lo[0] = it.box_min_x;
         lo[1] = it.box_min_y;
         lo[2] = it.box_min_z;
         hi[0] = it.box_max_x;
         hi[1] = it.box_max_y;
         hi[2] = it.box_max_z;
         // center and extent at doubled scale, swapped corners fold back
         for (int k = 0; k < fcull_pkg::NUM_AXES; k++) begin
            mid2[k] = lo[k] + hi[k];
            span[k] = hi[k] - lo[k];
            if (span[k] < 0) span[k] = -span[k];
         end
         for (int p = 0; p < fcull_pkg::NUM_PLANES; p++) begin
            coef = plane_store[p][fcull_pkg::COEF_D];
            m2 = coef <<< fcull_pkg::D_SHIFT;
            n2 = '0;
            for (int k = 0; k < fcull_pkg::NUM_AXES; k++) begin
               coef = plane_store[p][k];
               coef_mag = (coef < 0) ? -coef : coef;
               m2 = m2 + mid2[k] * coef;
               n2 = n2 + span[k] * coef_mag;
            end
            outer = m2 + n2;
            inner = m2 - n2;
            if (outer < 0) return fcull_pkg::VERDICT_OUTSIDE;
            if (inner < 0) v = fcull_pkg::VERDICT_INTERSECT;
         end
         return v;
      endfunction

      // accepted request: update planes or queue a verdict
      function void note_transfer(cull_item_type it);
         cull_result_type r;
         if (it.cmd == fcull_pkg::CMD_LOAD) begin
            // plane select six or seven writes nothing
            if (it.plane_sel < fcull_pkg::NUM_PLANES) begin
               plane_store[it.plane_sel][fcull_pkg::COEF_A] = it.coef_a;
               plane_store[it.plane_sel][fcull_pkg::COEF_B] = it.coef_b;
               plane_store[it.plane_sel][fcull_pkg::COEF_C] = it.coef_c;
               plane_store[it.plane_sel][fcull_pkg::COEF_D] = it.coef_d;
            end
            r.verdict  = fcull_pkg::VERDICT_INSIDE;
            r.was_load = 1'b1;
         end else begin
            r.verdict  = classify_box(it);
            r.was_load = 1'b0;
         end
         pending_verdicts.push_back(r);
      endfunction

      // accepted response against the oldest expectation
      function void check_result(logic [fcull_pkg::VERDICT_BITS-1:0] verdict,
                                 logic was_load);
         cull_result_type r;
         if (pending_verdicts.size() == 0) begin
            $error("unexpected response: verdict %0d was_load %0d", verdict, was_load);
            error_count++;
            return;
         end
         r = pending_verdicts.pop_front();
         if (verdict !== r.verdict) begin
            $error("verdict expected %0d actual %0d", r.verdict, verdict);
            error_count++;
         end
         if (was_load !== r.was_load) begin
            $error("was_load expected %0d actual %0d", r.was_load, was_load);
            error_count++;
         end
      endfunction

      function int outstanding();
         return pending_verdicts.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   fcull_req_if req_bus ();
   fcull_rsp_if rsp_bus ();

   cull_checker tracker = new();

   int burst_left = 0;
   int idle_cycles = 0;

   frustum_box_cull i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   // clock generation
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // signed value spread evenly over plus or minus span
   function automatic int spread(int unsigned span);
      return int'($urandom_range(0, 2 * span)) - int'(span);
   endfunction

   // value biased toward the ends of the field
   function automatic logic [fcull_pkg::FIELD_BITS-1:0] wild_value();
      case ($urandom_range(0, 5))
         0:       return {1'b1, {(fcull_pkg::FIELD_BITS-1){1'b0}}};
         1:       return {1'b0, {(fcull_pkg::FIELD_BITS-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // load item; the box fields carry noise
   function automatic cull_item_type make_load(int sel, int a, int b, int c, int d);
      cull_item_type it;
      it.cmd       = fcull_pkg::CMD_LOAD;
      it.plane_sel = fcull_pkg::PLANE_SEL_BITS'(sel);
      it.coef_a    = a;
      it.coef_b    = b;
      it.coef_c    = c;
      it.coef_d    = d;
      it.box_min_x = $urandom();
      it.box_min_y = $urandom();
      it.box_min_z = $urandom();
      it.box_max_x = $urandom();
      it.box_max_y = $urandom();
      it.box_max_z = $urandom();
      return it;
   endfunction

   // test item; plane select and coefficients carry noise
   function automatic cull_item_type make_box(int x0, int y0, int z0,
                                              int x1, int y1, int z1);
      cull_item_type it;
      it.cmd       = fcull_pkg::CMD_TEST;
      it.plane_sel = fcull_pkg::PLANE_SEL_BITS'($urandom_range(0, 7));
      it.coef_a    = $urandom();
      it.coef_b    = $urandom();
      it.coef_c    = $urandom();
      it.coef_d    = $urandom();
      it.box_min_x = x0;
      it.box_min_y = y0;
      it.box_min_z = z0;
      it.box_max_x = x1;
      it.box_max_y = y1;
      it.box_max_z = z1;
      return it;
   endfunction

   // present one request and hold it until the transfer, then maybe pause
   task automatic send_item(input cull_item_type it);
      int gap;
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= it.cmd;
      req_bus.plane_sel <= it.plane_sel;
      req_bus.coef_a    <= it.coef_a;
      req_bus.coef_b    <= it.coef_b;
      req_bus.coef_c    <= it.coef_c;
      req_bus.coef_d    <= it.coef_d;
      req_bus.box_min_x <= it.box_min_x;
      req_bus.box_min_y <= it.box_min_y;
      req_bus.box_min_z <= it.box_min_z;
      req_bus.box_max_x <= it.box_max_x;
      req_bus.box_max_y <= it.box_max_y;
      req_bus.box_max_z <= it.box_max_z;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      tracker.note_transfer(it);
      // bursts of random length separated by random gaps
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   // axis-aligned cube of the given half size around the origin
   task automatic load_cube(int half);
      send_item(make_load(0, ONE, 0, 0, half));
      send_item(make_load(1, -ONE, 0, 0, half));
      send_item(make_load(2, 0, ONE, 0, half));
      send_item(make_load(3, 0, -ONE, 0, half));
      send_item(make_load(4, 0, 0, ONE, half));
      send_item(make_load(5, 0, 0, -ONE, half));
   endtask

   // full set of six planes for a random phase
   task automatic load_phase_planes(layout_type layout);
      int coefs [fcull_pkg::NUM_AXES];
      int axis;
      int side;
      int d;
      for (int p = 0; p < fcull_pkg::NUM_PLANES; p++) begin
         axis = p / 2;
         side = (p % 2 == 0) ? 1 : -1;
         d = int'($urandom_range(5, 60)) * ONE;
         for (int k = 0; k < fcull_pkg::NUM_AXES; k++) begin
            if (layout == LAYOUT_WILD) coefs[k] = wild_value();
            else if (layout == LAYOUT_TILTED) coefs[k] = spread(ONE / 4);
            else coefs[k] = 0;
         end
         if (layout == LAYOUT_WILD) begin
            d = wild_value();
         end else begin
            coefs[axis] = coefs[axis] + side * ONE;
         end
         send_item(make_load(p, coefs[0], coefs[1], coefs[2], d));
      end
   endtask

   // random box suited to the layout, corners swapped now and then
   function automatic cull_item_type rand_box(layout_type layout);
      int lo [fcull_pkg::NUM_AXES];
      int hi [fcull_pkg::NUM_AXES];
      int c;
      int h;
      int t;
      for (int k = 0; k < fcull_pkg::NUM_AXES; k++) begin
         if (layout == LAYOUT_WILD) begin
            lo[k] = wild_value();
            hi[k] = wild_value();
         end else begin
            c = spread(80 * ONE);
            h = $urandom_range(0, 30 * ONE);
            lo[k] = c - h;
            hi[k] = c + h;
            if ($urandom_range(0, 7) == 0) begin
               t = lo[k];
               lo[k] = hi[k];
               hi[k] = t;
            end
         end
      end
      return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
   endfunction

   // response side: check transfers, stall on a changing pattern
   initial begin : response_side
      int mode;
      int left;
      int tick;
      mode = 0;
      left = 0;
      tick = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            tracker.check_result(rsp_bus.verdict, rsp_bus.was_load);
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(16, 160);
         end
         left--;
         tick++;
         case (mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
            2:       rsp_bus.ready <= ($urandom_range(0, 9) == 0);
            default: rsp_bus.ready <= ((tick % 7) < 2);
         endcase
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus
   initial begin : request_side
      layout_type layout;
      int         pick;
      req_bus.valid     <= 1'b0;
      req_bus.cmd       <= fcull_pkg::CMD_LOAD;
      req_bus.plane_sel <= '0;
      req_bus.coef_a    <= '0;
      req_bus.coef_b    <= '0;
      req_bus.coef_c    <= '0;
      req_bus.coef_d    <= '0;
      req_bus.box_min_x <= '0;
      req_bus.box_min_y <= '0;
      req_bus.box_min_z <= '0;
      req_bus.box_max_x <= '0;
      req_bus.box_max_y <= '0;
      req_bus.box_max_z <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all-zero planes after reset: everything is inside
      send_item(make_box(-ONE, -ONE, -ONE, ONE, ONE, ONE));
      // plane selects six and seven must not write
      send_item(make_load(6, -ONE, -ONE, -ONE, -ONE));
      send_item(make_load(7, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_item(make_box(5 * ONE, 5 * ONE, 5 * ONE, 9 * ONE, 9 * ONE, 9 * ONE));
      send_item(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));

      // cube of half size ten: inside, straddling, outside, swapped, point cases
      load_cube(10 * ONE);
      send_item(make_box(-2 * ONE, -2 * ONE, -2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE));
      send_item(make_box(5 * ONE, 0, 0, 15 * ONE, ONE, ONE));
      send_item(make_box(20 * ONE, 0, 0, 30 * ONE, ONE, ONE));
      send_item(make_box(15 * ONE, ONE, ONE, 5 * ONE, 0, 0));
      send_item(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
      send_item(make_box(0, 0, 0, 0, 0, 0));
      send_item(make_box(10 * ONE, 0, 0, 10 * ONE, 0, 0));

      // extreme coefficients against extreme boxes
      send_item(make_load(0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
      send_item(make_load(5, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
      send_item(make_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
      send_item(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_item(make_box(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                         32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
      send_item(make_load(7, ONE, ONE, ONE, ONE));
      send_item(make_box(0, 0, 0, ONE, ONE, ONE));

      // random phases: a full plane set, then boxes with stray loads mixed in
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         pick = $urandom_range(0, 4);
         layout = (pick < 2) ? LAYOUT_CUBE : (pick < 4) ? LAYOUT_TILTED : LAYOUT_WILD;
         if (phase == 0) layout = LAYOUT_WILD;
         load_phase_planes(layout);
         for (int n = 0; n < TESTS_PER_PHASE; n++) begin
            if ($urandom_range(0, 9) == 0)
               send_item(make_load($urandom_range(0, 7), wild_value(), wild_value(),
                                   wild_value(), wild_value()));
            else
               send_item(rand_box(layout));
         end
      end

      // drain
      req_bus.valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.error_count == 0 && tracker.outstanding() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
